// ===== rtl/wildcard_byte_signature_scan_defines.svh =====
// Assertion macros used by the scanner module.
`ifndef WILDCARD_BYTE_SIGNATURE_SCAN_DEFINES_SVH
`define WILDCARD_BYTE_SIGNATURE_SCAN_DEFINES_SVH

// Same-cycle implication, checked while the block is out of reset.
`define WBSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wbss assertion failed");

// Next-cycle implication, checked while the block is out of reset.
`define WBSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wbss assertion failed");

`endif

// ===== rtl/wbss_pkg.sv =====
package wbss_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 16;
    localparam int ADDRESS_BITS_DEF      = 48;

    localparam int DATA_W      = 8;
    localparam int ADDR_FLD_W  = 48;
    localparam int STATUS_W    = 2;
    localparam int PAT_W       = 64;
    localparam int CARE_W      = 16;
    localparam int LEN_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_CARE_MASK    = 2'd2,
        CFG_PATTERN_LEN  = 2'd3
    } t_cfg_idx;

    localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNIQUE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_AMBIG  = 2'd2;

endpackage

// ===== rtl/wildcard_byte_signature_scan.sv =====
// Masked byte signature scanner. Bytes arrive one transfer per cycle on the slave
// stream, each with its address, a region-start flag in tuser and the end of the
// scan in tlast. A signature of up to MAX_PATTERN_BYTES bytes with per-byte
// wildcards (byte 0 always compared) is matched against a window of the latest
// bytes of the current region. On the last byte one result transfer gives the
// status (none, unique, ambiguous) and the start address of the first match. The
// block takes one byte per cycle but for pauses; the last byte passes the input
// and result registers. The input pauses only while the last byte of a scan waits
// in the input register behind a finished result that the sink has not yet taken.
// Configuration must be written only while no byte is in flight; not enforced.
`include "wildcard_byte_signature_scan_defines.svh"

module wildcard_byte_signature_scan #(
    parameter int MAX_PATTERN_BYTES = wbss_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int ADDRESS_BITS      = wbss_pkg::ADDRESS_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Fields from bit 0: data_byte[7:0], byte_address[55:8].
    input  logic [wbss_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // Fields from bit 0: region_start.
    input  logic                               i_s_axis_tuser,
    input  logic                               i_s_axis_tlast,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // Fields from bit 0: status[1:0], match_address[49:2], zero fill.
    output logic [wbss_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic                               i_cfg_we,
    input  logic [wbss_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wbss_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int ADDR_W = (ADDRESS_BITS < wbss_pkg::ADDR_FLD_W)
                          ? ADDRESS_BITS : wbss_pkg::ADDR_FLD_W;
    localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int PAD_W  = wbss_pkg::OUT_TDATA_W - wbss_pkg::ADDR_FLD_W
                          - wbss_pkg::STATUS_W;

    logic [wbss_pkg::PAT_W-1:0]  r_pat_lo;
    logic [wbss_pkg::PAT_W-1:0]  r_pat_hi;
    logic [wbss_pkg::CARE_W-1:0] r_care;
    logic [wbss_pkg::LEN_W-1:0]  r_len;

    logic                           r_in_valid;
    logic [wbss_pkg::DATA_W-1:0]    r_in_data;
    logic [ADDR_W-1:0]              r_in_addr;
    logic                           r_in_start;
    logic                           r_in_last;

    logic [MAX_PATTERN_BYTES-1:0][wbss_pkg::DATA_W-1:0] r_win;
    logic [MAX_PATTERN_BYTES-1:0][wbss_pkg::DATA_W-1:0] n_win;
    logic [FILL_W-1:0]              r_fill;
    logic [FILL_W-1:0]              n_fill;
    logic [FILL_W-1:0]              fill_base;
    logic [wbss_pkg::STATUS_W-1:0]  r_count;
    logic [wbss_pkg::STATUS_W-1:0]  n_count;
    logic [ADDR_W-1:0]              r_first;
    logic [ADDR_W-1:0]              n_first;

    logic                           r_out_valid;
    logic [wbss_pkg::STATUS_W-1:0]  r_out_status;
    logic [wbss_pkg::ADDR_FLD_W-1:0] r_out_addr;

    logic [wbss_pkg::LEN_W-1:0]     eff_len;
    logic                           s_accept;
    logic                           advance;
    logic                           hit;
    logic                           found;

    always_comb begin
        priority if (r_len == '0) begin
            eff_len = wbss_pkg::LEN_W'(1);
        end else if (r_len > wbss_pkg::LEN_W'(MAX_PATTERN_BYTES)) begin
            eff_len = wbss_pkg::LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            eff_len = r_len;
        end
    end

    assign o_s_axis_tready = !r_in_valid || !r_in_last || !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign advance         = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);

    always_comb begin
        n_win[0] = r_in_data;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    assign fill_base = r_in_start ? '0 : r_fill;
    assign n_fill    = (fill_base < FILL_W'(MAX_PATTERN_BYTES))
                     ? fill_base + FILL_W'(1) : fill_base;

    wbss_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .i_window       (n_win),
        .i_pattern_low  (r_pat_lo),
        .i_pattern_high (r_pat_hi),
        .i_care_mask    (r_care),
        .i_length       (eff_len),
        .o_hit          (hit)
    );

    assign found = hit && (wbss_pkg::LEN_W'(n_fill) >= eff_len);

    always_comb begin
        n_count = r_count;
        n_first = r_first;
        if (found) begin
            if (r_count == wbss_pkg::STATUS_NONE) begin
                n_first = r_in_addr - ADDR_W'(eff_len - wbss_pkg::LEN_W'(1));
            end
            if (r_count != wbss_pkg::STATUS_AMBIG) begin
                n_count = r_count + wbss_pkg::STATUS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo    <= '0;
            r_pat_hi    <= '0;
            r_care      <= wbss_pkg::CARE_W'(1);
            r_len       <= wbss_pkg::LEN_W'(1);
            r_in_valid  <= 1'b0;
            r_fill      <= '0;
            r_count     <= wbss_pkg::STATUS_NONE;
            r_first     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (wbss_pkg::t_cfg_idx'(i_cfg_index))
                    wbss_pkg::CFG_PATTERN_LOW: begin
                        r_pat_lo <= i_cfg_data;
                    end
                    wbss_pkg::CFG_PATTERN_HIGH: begin
                        r_pat_hi <= i_cfg_data;
                    end
                    wbss_pkg::CFG_CARE_MASK: begin
                        r_care <= i_cfg_data[wbss_pkg::CARE_W-1:0];
                    end
                    wbss_pkg::CFG_PATTERN_LEN: begin
                        r_len <= i_cfg_data[wbss_pkg::LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                if (r_in_last) begin
                    r_fill  <= '0;
                    r_count <= wbss_pkg::STATUS_NONE;
                    r_first <= '0;
                end else begin
                    r_fill  <= n_fill;
                    r_count <= n_count;
                    r_first <= n_first;
                end
            end

            if (advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_data  <= i_s_axis_tdata[wbss_pkg::DATA_W-1:0];
            r_in_addr  <= i_s_axis_tdata[wbss_pkg::DATA_W +: ADDR_W];
            r_in_start <= i_s_axis_tuser;
            r_in_last  <= i_s_axis_tlast;
        end
        if (advance) begin
            r_win <= n_win;
        end
        if (advance && r_in_last) begin
            r_out_status <= n_count;
            r_out_addr   <= wbss_pkg::ADDR_FLD_W'(n_first);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {PAD_W'(0), r_out_addr, r_out_status};

    `WBSS_ASSERT_NOW(a_count_saturates, i_clk, i_rst_n, 1'b1,
        r_count != 2'd3)
    `WBSS_ASSERT_NOW(a_fill_bounded, i_clk, i_rst_n, 1'b1,
        r_fill <= FILL_W'(MAX_PATTERN_BYTES))
    `WBSS_ASSERT_NEXT(a_scan_state_cleared, i_clk, i_rst_n, advance && r_in_last,
        r_count == wbss_pkg::STATUS_NONE && r_fill == '0 && r_first == '0 && r_out_valid)
    `WBSS_ASSERT_NOW(a_stall_only_on_held_result, i_clk, i_rst_n, !o_s_axis_tready,
        r_in_valid && r_in_last && r_out_valid)
    `WBSS_ASSERT_NOW(a_no_match_no_address, i_clk, i_rst_n, r_count == wbss_pkg::STATUS_NONE,
        r_first == '0)

endmodule

// ===== rtl/wbss_match.sv =====
module wbss_match #(
    parameter int MAX_PATTERN_BYTES = wbss_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  logic [MAX_PATTERN_BYTES-1:0][wbss_pkg::DATA_W-1:0] i_window,
    input  logic [wbss_pkg::PAT_W-1:0]                         i_pattern_low,
    input  logic [wbss_pkg::PAT_W-1:0]                         i_pattern_high,
    input  logic [wbss_pkg::CARE_W-1:0]                        i_care_mask,
    input  logic [wbss_pkg::LEN_W-1:0]                         i_length,
    output logic                                               o_hit
);

    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [2*wbss_pkg::PAT_W-1:0] pattern;
    logic [wbss_pkg::LEN_W-1:0]   pos [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] miss;

    assign pattern = {i_pattern_high, i_pattern_low};

    // Signature byte i lines up with the window entry that arrived len-1-i bytes ago.
    always_comb begin
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            pos[i] = i_length - wbss_pkg::LEN_W'(1) - wbss_pkg::LEN_W'(i);
            miss[i] = (wbss_pkg::LEN_W'(i) < i_length)
                && ((i == 0) || i_care_mask[i])
                && (i_window[pos[i][IDX_W-1:0]]
                    != pattern[wbss_pkg::DATA_W*i +: wbss_pkg::DATA_W]);
        end
    end

    assign o_hit = ~|miss;

endmodule

// ===== tb/wildcard_byte_signature_scan_tb.sv =====
`timescale 1ns / 1ps

module wildcard_byte_signature_scan_tb;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [wbss_pkg::STATUS_W-1:0]   status;
        logic [wbss_pkg::ADDR_FLD_W-1:0] addr;
    } t_scan_report;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic [wbss_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                             s_tuser = 1'b0;
    logic                             s_tlast = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [wbss_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic                             cfg_we = 1'b0;
    wbss_pkg::t_cfg_idx               cfg_index = wbss_pkg::CFG_PATTERN_LOW;
    logic [wbss_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    logic [wbss_pkg::PAT_W-1:0]  sig_lo = '0;
    logic [wbss_pkg::PAT_W-1:0]  sig_hi = '0;
    logic [wbss_pkg::CARE_W-1:0] care = 16'h0001;
    logic [wbss_pkg::LEN_W-1:0]  len_reg = 5'd1;
    logic [7:0]        win [16] = '{default: 8'h00};
    int                win_fill = 0;
    int                hit_count = 0;
    logic [wbss_pkg::ADDR_FLD_W-1:0] first_hit = '0;

    t_scan_report expected_reports[$];
    int n_errors = 0;
    int bytes_sent = 0;
    int n_scans = 0;
    int n_none = 0;
    int n_unique = 0;
    int n_ambig = 0;
    int gap_pct = 0;
    int sink_hold = 0;
    int idle_cycles = 0;

    always #5 clk = ~clk;

    wildcard_byte_signature_scan dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    function automatic int eff_len();
        if (len_reg == 5'd0) return 1;
        if (len_reg > 5'd16) return 16;
        return int'(len_reg);
    endfunction

    function automatic logic [7:0] sig_byte(input int i);
        if (i < 8) return sig_lo[8*i +: 8];
        return sig_hi[8*(i-8) +: 8];
    endfunction

    function automatic bit window_hit(input int n);
        for (int i = 0; i < n; i++) begin
            if ((i == 0 || care[i]) && win[n-1-i] != sig_byte(i)) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic scan_model_step(input logic [7:0] d,
                                   input logic [wbss_pkg::ADDR_FLD_W-1:0] a,
                                   input logic rs, input logic se);
        int n;
        t_scan_report r;
        n = eff_len();
        if (rs) win_fill = 0;
        for (int k = 15; k > 0; k--) win[k] = win[k-1];
        win[0] = d;
        if (win_fill < 16) win_fill++;
        if (win_fill >= n && window_hit(n)) begin
            if (hit_count == 0) first_hit = a - wbss_pkg::ADDR_FLD_W'(n - 1);
            if (hit_count < 2) hit_count++;
        end
        if (se) begin
            r.status = (hit_count == 0) ? wbss_pkg::STATUS_NONE :
                       (hit_count == 1) ? wbss_pkg::STATUS_UNIQUE : wbss_pkg::STATUS_AMBIG;
            r.addr = (hit_count != 0) ? first_hit : '0;
            expected_reports = {expected_reports, r};
            n_scans++;
            win_fill = 0;
            hit_count = 0;
            first_hit = '0;
        end
    endtask

    task automatic send_byte(input logic [7:0] d, input logic [wbss_pkg::ADDR_FLD_W-1:0] a,
                             input logic rs, input logic se);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {a, d};
        s_tuser  <= rs;
        s_tlast  <= se;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
        scan_model_step(d, a, rs, se);
    endtask

    task automatic write_reg(input wbss_pkg::t_cfg_idx idx,
                             input logic [wbss_pkg::CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            wbss_pkg::CFG_PATTERN_LOW:  sig_lo = v;
            wbss_pkg::CFG_PATTERN_HIGH: sig_hi = v;
            wbss_pkg::CFG_CARE_MASK:    care = v[wbss_pkg::CARE_W-1:0];
            wbss_pkg::CFG_PATTERN_LEN:  len_reg = v[wbss_pkg::LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Bytes without tlast give no result, so the fixed pause covers the pipeline.
    task automatic wait_reports_drained();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [wbss_pkg::ADDR_FLD_W-1:0] pick_base();
        case ($urandom_range(0, 5))
            0: return 48'hFFFF_FFFF_FFFF - wbss_pkg::ADDR_FLD_W'($urandom_range(0, 24));
            1: return wbss_pkg::ADDR_FLD_W'($urandom_range(0, 24));
            default: return wbss_pkg::ADDR_FLD_W'({$urandom, $urandom});
        endcase
    endfunction

    task automatic run_scan(input int n_bytes, input bit close);
        logic [wbss_pkg::ADDR_FLD_W-1:0] a;
        logic [7:0] d;
        int n;
        int pos;
        bit rs;
        a = pick_base();
        n = eff_len();
        pos = -1;
        for (int i = 0; i < n_bytes; i++) begin
            rs = (i == 0) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 15) == 0);
            if (rs && $urandom_range(0, 1) == 1) a = pick_base();
            if (pos < 0 && $urandom_range(0, 99) < 35) pos = 0;
            if (pos >= 0) begin
                d = (pos == 0 || care[pos]) ? sig_byte(pos) : 8'($urandom);
                if ($urandom_range(0, 19) == 0) d = ~d;
                pos = (pos + 1 == n) ? -1 : pos + 1;
            end else begin
                d = 8'($urandom);
            end
            send_byte(d, a, rs, close && (i == n_bytes - 1));
            a++;
        end
    endtask

    task automatic run_phase(input int n_items, input int gap, input bit hold_midway);
        logic [wbss_pkg::LEN_W-1:0]  plen;
        logic [wbss_pkg::CARE_W-1:0] cmask;
        int target;
        int scan_n;
        bit close;
        wait_reports_drained();
        gap_pct = gap;
        case ($urandom_range(0, 7))
            0: plen = 5'd0;
            1: plen = 5'd1;
            2: plen = 5'd16;
            3: plen = wbss_pkg::LEN_W'($urandom_range(17, 31));
            default: plen = wbss_pkg::LEN_W'($urandom_range(2, 8));
        endcase
        case ($urandom_range(0, 3))
            0: cmask = '0;
            1: cmask = '1;
            default: cmask = wbss_pkg::CARE_W'($urandom);
        endcase
        write_reg(wbss_pkg::CFG_PATTERN_LOW,
                  ($urandom_range(0, 7) == 0) ? '1 : {$urandom, $urandom});
        write_reg(wbss_pkg::CFG_PATTERN_HIGH,
                  ($urandom_range(0, 7) == 0) ? '0 : {$urandom, $urandom});
        write_reg(wbss_pkg::CFG_CARE_MASK, ({$urandom, $urandom} & ~64'hFFFF) | 64'(cmask));
        write_reg(wbss_pkg::CFG_PATTERN_LEN, ({$urandom, $urandom} & ~64'h1F) | 64'(plen));
        target = bytes_sent + n_items;
        while (bytes_sent < target) begin
            if (hold_midway && bytes_sent >= target - n_items / 2) begin
                wait_reports_drained();
                hold_midway = 1'b0;
            end
            scan_n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 32);
            close = (bytes_sent + scan_n < target) || ($urandom_range(0, 2) != 0);
            run_scan(scan_n, close);
        end
    endtask

    task automatic test_reset_defaults();
        send_byte(8'h00, 48'h0, 1'b0, 1'b0);
        send_byte(8'hFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);
        send_byte(8'h00, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1);
    endtask

    task automatic test_wildcards_and_regions();
        wait_reports_drained();
        write_reg(wbss_pkg::CFG_PATTERN_LOW, 64'h0000_0000_4433_2211);
        write_reg(wbss_pkg::CFG_CARE_MASK, 64'h0008);
        write_reg(wbss_pkg::CFG_PATTERN_LEN, 64'd4);
        send_byte(8'h11, 48'hFFFF_FFFF_FFFE, 1'b1, 1'b0);
        send_byte(8'h99, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);
        send_byte(8'h99, 48'h0, 1'b0, 1'b0);
        send_byte(8'h44, 48'h1, 1'b0, 1'b0);
        send_byte(8'h11, 48'h2, 1'b0, 1'b0);
        send_byte(8'h22, 48'h3, 1'b0, 1'b0);
        send_byte(8'h33, 48'h4, 1'b0, 1'b0);
        send_byte(8'h44, 48'h5, 1'b1, 1'b1);
    endtask

    task automatic test_length_limits();
        wait_reports_drained();
        write_reg(wbss_pkg::CFG_PATTERN_LEN, 64'd0);
        send_byte(8'h11, 48'h0, 1'b1, 1'b1);
        wait_reports_drained();
        write_reg(wbss_pkg::CFG_PATTERN_HIGH, '1);
        write_reg(wbss_pkg::CFG_CARE_MASK, 64'h0000);
        write_reg(wbss_pkg::CFG_PATTERN_LEN, 64'd31);
        for (int i = 0; i < 16; i++) begin
            send_byte((i == 0) ? sig_byte(0) : 8'($urandom), 48'h1234_5678_9AB0 + 48'(i),
                      1'(i == 0), 1'(i == 15));
        end
    endtask

    task automatic test_random_scans();
        for (int p = 0; p < 10; p++) begin
            run_phase(90, (p == 3) ? 0 : $urandom_range(10, 40), p == 5);
        end
    endtask

    task automatic test_back_to_back();
        for (int p = 0; p < 2; p++) run_phase(100, 0, 1'b0);
    endtask

    always @(posedge clk) begin
        t_scan_report want;
        if (!rst_n) begin
            m_tready <= 1'b0;
            idle_cycles = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    n_errors++;
                    $error("unexpected result transfer: status %0d, match_address %h",
                           m_tdata[1:0], m_tdata[49:2]);
                end else begin
                    want = expected_reports.pop_front();
                    if (m_tdata[1:0] !== want.status) begin
                        n_errors++;
                        $error("status: expected %0d, actual %0d", want.status, m_tdata[1:0]);
                    end
                    if (m_tdata[49:2] !== want.addr) begin
                        n_errors++;
                        $error("match_address: expected %h, actual %h", want.addr, m_tdata[49:2]);
                    end
                    if (m_tdata[55:50] !== '0) begin
                        n_errors++;
                        $error("zero fill: expected 0, actual %h", m_tdata[55:50]);
                    end
                    case (want.status)
                        wbss_pkg::STATUS_NONE:   n_none++;
                        wbss_pkg::STATUS_UNIQUE: n_unique++;
                        default:                 n_ambig++;
                    endcase
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
                sink_hold = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles, %0d results outstanding.",
                         idle_cycles, expected_reports.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_wildcards_and_regions();
        test_length_limits();
        test_random_scans();
        test_back_to_back();
        wait_reports_drained();
        repeat (10) @(posedge clk);
        $display("Scanned %0d bytes in %0d scans: %0d not found, %0d unique, %0d ambiguous.",
                 bytes_sent, n_scans, n_none, n_unique, n_ambig);
        $display("Lengths from 0 to 31, wildcard masks, region splits and address wrap, %s",
                 "with and without stalls on both streams.");
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== wildcard_byte_signature_scan.f =====
+incdir+rtl
rtl/wbss_pkg.sv
rtl/wbss_match.sv
rtl/wildcard_byte_signature_scan.sv
tb/wildcard_byte_signature_scan_tb.sv
